// ----- src/length_prefixed_byte_loader_defines.svh -----
// Assertion macros used by the loader's top-level RTL file.
`ifndef LENGTH_PREFIXED_BYTE_LOADER_DEFINES_SVH
`define LENGTH_PREFIXED_BYTE_LOADER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LPBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define LPBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lpbl_pkg.sv -----
// Types and constants of the length-prefixed byte loader.
package lpbl_pkg;

  // Command codes of an input word
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Special received characters
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_DEL  = 8'h7F;

  localparam int unsigned ACCUM_W  = 20;
  localparam int unsigned TICK_W   = 24;
  localparam logic [ACCUM_W-1:0] ACCUM_MAX = 20'hFFFFF;
  localparam logic [TICK_W-1:0]  TICK_MAX  = 24'hFFFFFF;
  localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 24'd200000;

  // Reciprocal of ten, scaled by 2^23; exact for every accumulator value
  localparam logic [ACCUM_W-1:0] RECIP10   = 20'hCCCCD;
  localparam int unsigned        RECIP10_SH = 23;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_ACCEPTED   = 3'd1,
    EV_BAD_LENGTH = 3'd2,
    EV_BAD_CHAR   = 3'd3,
    EV_TIMEOUT    = 3'd4,
    EV_COMPLETE   = 3'd5,
    EV_ERASED     = 3'd6
  } evt_t;

  // One result word
  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    evt_t       event_res;
    logic [7:0] store_index;
    logic [8:0] loaded_length;
    logic       back_to_ready;
  } res_t;

endpackage

// ----- src/lpbl_chan_if.sv -----
// Valid/ready channels of the loader: command input and result output.
interface lpbl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface lpbl_out_if;
  logic               valid;
  logic               ready;
  logic               echo_valid;
  logic [7:0]         echo_byte;
  lpbl_pkg::evt_t     event_res;
  logic [7:0]         store_index;
  logic [8:0]         loaded_length;
  logic               back_to_ready;

  modport source (output valid, output echo_valid, output echo_byte, output event_res,
                  output store_index, output loaded_length, output back_to_ready,
                  input ready);
  modport sink   (input valid, input echo_valid, input echo_byte, input event_res,
                  input store_index, input loaded_length, input back_to_ready,
                  output ready);
endinterface

// ----- src/lpbl_store.sv -----
// Payload buffer: synchronous single-port memory, one byte written per cycle when wr_en is high.
module lpbl_store #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data
);

  logic [7:0] mem [DEPTH];

  // Store payload word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ----- src/lpbl_ctrl.sv -----
// Loader sequencer: length parsing, payload counting, timeout and timeout register.
module lpbl_ctrl #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned LEN_W  = $clog2(DEPTH + 1),
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic [1:0]                cmd,
  input  logic [7:0]                rx_byte,
  input  logic                      cfg_wr_en,
  input  logic [lpbl_pkg::TICK_W-1:0] cfg_wr_data,
  output lpbl_pkg::res_t            res,
  output logic                      wr_en,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [7:0]                wr_data
);

  localparam int unsigned AW = lpbl_pkg::ACCUM_W;
  localparam int unsigned TW = lpbl_pkg::TICK_W;

  typedef enum logic [1:0] {
    PH_READY   = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [AW-1:0]       accum_r, accum_nxt;
  logic [LEN_W-1:0]    target_r, target_nxt;
  logic [LEN_W-1:0]    pos_r, pos_nxt;
  logic [TW-1:0]       idle_r, idle_nxt;
  logic [TW-1:0]       timeout_r;
  logic                wr_req;

  logic [TW-1:0]       times10;
  logic [TW-1:0]       digit_sum;
  logic [2*AW-1:0]     recip_prod;
  logic [AW-1:0]       accum_div10;
  logic [LEN_W-1:0]    pos_inc;
  logic [TW-1:0]       idle_inc;
  logic [LEN_W+8:0]    len_ext;
  logic [LEN_W+7:0]    pos_ext;

  // Accumulator arithmetic: times ten plus digit, and divide by ten
  assign times10     = TW'({accum_r, 3'b000}) + TW'({accum_r, 1'b0});
  assign digit_sum   = times10 + TW'(rx_byte - lpbl_pkg::CHAR_ZERO);
  assign recip_prod  = {{AW{1'b0}}, accum_r} * {{AW{1'b0}}, lpbl_pkg::RECIP10};
  assign accum_div10 = AW'(recip_prod >> lpbl_pkg::RECIP10_SH);

  assign pos_inc  = pos_r + LEN_W'(1);
  assign idle_inc = (idle_r == lpbl_pkg::TICK_MAX) ? idle_r : idle_r + TW'(1);
  assign len_ext  = {9'b0, target_r};
  assign pos_ext  = {8'b0, pos_r};

  // Next state and result of the current word
  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    target_nxt = target_r;
    pos_nxt    = pos_r;
    idle_nxt   = idle_r;
    wr_req     = 1'b0;
    res        = '0;
    res.event_res = lpbl_pkg::EV_NONE;
    case (cmd)
      lpbl_pkg::CMD_START: begin
        phase_nxt  = PH_LENGTH;
        accum_nxt  = '0;
        target_nxt = '0;
        pos_nxt    = '0;
        idle_nxt   = '0;
      end
      lpbl_pkg::CMD_BYTE: begin
        case (phase_r)
          PH_LENGTH: begin
            if (rx_byte >= lpbl_pkg::CHAR_ZERO && rx_byte <= lpbl_pkg::CHAR_NINE) begin
              accum_nxt = (digit_sum > TW'(lpbl_pkg::ACCUM_MAX)) ?
                          lpbl_pkg::ACCUM_MAX : digit_sum[AW-1:0];
              res.echo_valid = 1'b1;
              res.echo_byte  = rx_byte;
            end else if (rx_byte == lpbl_pkg::CHAR_CR) begin
              if (accum_r != '0 && accum_r <= AW'(DEPTH)) begin
                target_nxt = accum_r[LEN_W-1:0];
                accum_nxt  = '0;
                pos_nxt    = '0;
                idle_nxt   = '0;
                phase_nxt  = PH_PAYLOAD;
                res.event_res     = lpbl_pkg::EV_ACCEPTED;
                res.loaded_length = 9'(accum_r[LEN_W-1:0]);
              end else begin
                phase_nxt  = PH_READY;
                accum_nxt  = '0;
                target_nxt = '0;
                pos_nxt    = '0;
                idle_nxt   = '0;
                res.event_res     = lpbl_pkg::EV_BAD_LENGTH;
                res.back_to_ready = 1'b1;
              end
            end else if (rx_byte == lpbl_pkg::CHAR_DEL) begin
              if (accum_r != '0) begin
                accum_nxt     = accum_div10;
                res.event_res = lpbl_pkg::EV_ERASED;
              end
            end else begin
              phase_nxt  = PH_READY;
              accum_nxt  = '0;
              target_nxt = '0;
              pos_nxt    = '0;
              idle_nxt   = '0;
              res.event_res     = lpbl_pkg::EV_BAD_CHAR;
              res.back_to_ready = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            // Store, echo and advance; the position is always below the target here
            wr_req          = 1'b1;
            res.echo_valid  = 1'b1;
            res.echo_byte   = rx_byte;
            res.store_index = pos_ext[7:0];
            pos_nxt         = pos_inc;
            idle_nxt        = '0;
            if (pos_inc >= target_r) begin
              phase_nxt  = PH_READY;
              accum_nxt  = '0;
              target_nxt = '0;
              pos_nxt    = '0;
              res.event_res     = lpbl_pkg::EV_COMPLETE;
              res.loaded_length = len_ext[8:0];
              res.back_to_ready = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      lpbl_pkg::CMD_TICK: begin
        if (phase_r == PH_PAYLOAD) begin
          idle_nxt = idle_inc;
          if (idle_inc >= timeout_r) begin
            phase_nxt  = PH_READY;
            accum_nxt  = '0;
            target_nxt = '0;
            pos_nxt    = '0;
            idle_nxt   = '0;
            res.event_res     = lpbl_pkg::EV_TIMEOUT;
            res.back_to_ready = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_en   = fire && wr_req;
  assign wr_addr = pos_r[ADDR_W-1:0];
  assign wr_data = rx_byte;

  // Advance state on each accepted word; hold the timeout register until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_READY;
      accum_r   <= '0;
      target_r  <= '0;
      pos_r     <= '0;
      idle_r    <= '0;
      timeout_r <= lpbl_pkg::TIMEOUT_RESET;
    end else begin
      if (fire) begin
        phase_r  <= phase_nxt;
        accum_r  <= accum_nxt;
        target_r <= target_nxt;
        pos_r    <= pos_nxt;
        idle_r   <= idle_nxt;
      end
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ----- src/lpbl_outbuf.sv -----
// Result register: holds one result word until the sink takes it.
module lpbl_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  lpbl_pkg::res_t      res,
  output logic                room,
  lpbl_out_if.source          out_ch
);

  logic           valid_r, valid_nxt;
  lpbl_pkg::res_t res_r;

  // Accept a new word when empty or when the held word leaves this cycle
  assign room      = !valid_r || out_ch.ready;
  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on load
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.echo_valid    = res_r.echo_valid;
  assign out_ch.echo_byte     = res_r.echo_byte;
  assign out_ch.event_res     = res_r.event_res;
  assign out_ch.store_index   = res_r.store_index;
  assign out_ch.loaded_length = res_r.loaded_length;
  assign out_ch.back_to_ready = res_r.back_to_ready;

endmodule

// ----- src/length_prefixed_byte_loader.sv -----
// The result word of an accepted word is held in the result register before it shows on the output.
// Throughput: one word per cycle; a new word is taken whenever the result register
// is empty or its word is taken in the same cycle.
// Payload bytes go to a single-port buffer memory, one write per accepted payload byte.
// Reset (synchronous, rst_n low) returns the loader to ready, clears the counters, empties
// the result register and loads the timeout register with 200000; the buffer is not cleared.
`include "length_prefixed_byte_loader_defines.svh"
module length_prefixed_byte_loader #(
  parameter int unsigned BUFFER_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lpbl_in_if.sink                     in_ch,
  lpbl_out_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [lpbl_pkg::TICK_W-1:0] cfg_wr_data
);

  localparam int unsigned LEN_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);

  logic                fire;
  logic                room;
  lpbl_pkg::res_t      res;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [7:0]          wr_data;

  assign in_ch.ready = room;
  assign fire        = in_ch.valid && room;

  lpbl_ctrl #(
    .DEPTH  (BUFFER_DEPTH),
    .LEN_W  (LEN_W),
    .ADDR_W (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .cmd         (in_ch.cmd),
    .rx_byte     (in_ch.rx_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  lpbl_store #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lpbl_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (fire),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

  // Every accepted word produces a result word on the next cycle
  `LPBL_ASSERT_NEXT(a_result_follows, fire, out_ch.valid, "accepted word gave no result")

  // Return to ready only on a terminating event
  `LPBL_ASSERT_NOW(a_ready_event, out_ch.valid && out_ch.back_to_ready, (out_ch.event_res == lpbl_pkg::EV_BAD_LENGTH || out_ch.event_res == lpbl_pkg::EV_BAD_CHAR || out_ch.event_res == lpbl_pkg::EV_TIMEOUT || out_ch.event_res == lpbl_pkg::EV_COMPLETE), "back_to_ready without terminating event")

  // Loaded length shows only on accepted or complete events
  `LPBL_ASSERT_NOW(a_len_event, out_ch.valid && out_ch.loaded_length != 9'd0, (out_ch.event_res == lpbl_pkg::EV_ACCEPTED || out_ch.event_res == lpbl_pkg::EV_COMPLETE), "loaded_length on wrong event")

  // A buffer write happens only for an accepted word
  `LPBL_ASSERT_NOW(a_write_fire, wr_en, fire, "buffer written without accepted word")

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the length-prefixed byte loader: directed and random command words, predicted results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpbl_pkg::*;

  localparam int unsigned DEPTH          = 256;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [1:0]  CMD_SPARE      = 2'd3;

  typedef enum logic [1:0] {PH_READY, PH_LENGTH, PH_PAYLOAD} load_phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                cfg_wr_en;
  logic [TICK_W-1:0]   cfg_wr_data;

  lpbl_in_if  in_if ();
  lpbl_out_if out_if ();

  length_prefixed_byte_loader #(
    .BUFFER_DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Loader state as seen by the predictor
  load_phase_t         ld_phase    = PH_READY;
  logic [ACCUM_W-1:0]  len_accum   = '0;
  logic [8:0]          tgt_len     = '0;
  logic [8:0]          wr_pos      = '0;
  logic [TICK_W-1:0]   idle_cnt    = '0;
  logic [TICK_W-1:0]   tmo_setting = TIMEOUT_RESET;

  word_t cmd_words[$];
  res_t  loader_results_due[$];

  logic        in_taken;
  int unsigned sender_gap;
  int unsigned sink_hold;
  bit          long_hold_done;
  bit          calm_tail;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned stall_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Drop back to ready and clear the counters
  function automatic void clear_load();
    ld_phase  = PH_READY;
    len_accum = '0;
    tgt_len   = '0;
    wr_pos    = '0;
    idle_cnt  = '0;
  endfunction

  // Advance the loader by one command word and return the result word it yields
  function automatic res_t step_loader(input logic [1:0] c, input logic [7:0] b);
    res_t        r;
    logic [31:0] grown;
    r = '0;
    case (c)
      CMD_START: begin
        clear_load();
        ld_phase = PH_LENGTH;
      end
      CMD_BYTE: begin
        if (ld_phase == PH_LENGTH) begin
          if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            grown = 32'(len_accum) * 32'd10 + 32'(b) - 32'(CHAR_ZERO);
            len_accum = (grown > 32'(ACCUM_MAX)) ? ACCUM_MAX : grown[ACCUM_W-1:0];
            r.echo_valid = 1'b1;
            r.echo_byte  = b;
          end else if (b == CHAR_CR) begin
            if (len_accum >= 1 && len_accum <= DEPTH) begin
              tgt_len   = len_accum[8:0];
              len_accum = '0;
              wr_pos    = '0;
              idle_cnt  = '0;
              ld_phase  = PH_PAYLOAD;
              r.event_res     = EV_ACCEPTED;
              r.loaded_length = tgt_len;
            end else begin
              clear_load();
              r.event_res     = EV_BAD_LENGTH;
              r.back_to_ready = 1'b1;
            end
          end else if (b == CHAR_DEL) begin
            // erase only when there is a digit to erase
            if (len_accum != 0) begin
              len_accum   = ACCUM_W'(len_accum / 10);
              r.event_res = EV_ERASED;
            end
          end else begin
            clear_load();
            r.event_res     = EV_BAD_CHAR;
            r.back_to_ready = 1'b1;
          end
        end else if (ld_phase == PH_PAYLOAD) begin
          if (wr_pos < tgt_len && wr_pos < DEPTH) begin
            r.store_index = wr_pos[7:0];
            r.echo_valid  = 1'b1;
            r.echo_byte   = b;
            wr_pos        = wr_pos + 9'd1;
            idle_cnt      = '0;
          end
          if (wr_pos >= tgt_len) begin
            r.loaded_length = tgt_len;
            clear_load();
            r.event_res     = EV_COMPLETE;
            r.back_to_ready = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (ld_phase == PH_PAYLOAD) begin
          if (idle_cnt != TICK_MAX) idle_cnt = idle_cnt + 1'b1;
          if (idle_cnt >= tmo_setting) begin
            clear_load();
            r.event_res     = EV_TIMEOUT;
            r.back_to_ready = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_word(input logic [1:0] c, input logic [7:0] d);
    word_t w;
    w.cmd  = c;
    w.data = d;
    cmd_words.push_back(w);
  endtask

  // Any byte that is neither a digit nor CR nor DEL
  function automatic logic [7:0] stray_char();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_CR || b == CHAR_DEL);
    return b;
  endfunction

  task automatic push_decimal(input int unsigned v, input int unsigned lead_zeros);
    int unsigned digs[$];
    repeat (lead_zeros) push_word(CMD_BYTE, CHAR_ZERO);
    do begin
      digs.push_front(v % 10);
      v = v / 10;
    end while (v != 0);
    foreach (digs[k]) push_word(CMD_BYTE, CHAR_ZERO + 8'(digs[k]));
  endtask

  // One load attempt: start, a length, then payload with ticks, or a rejected length or stray character
  task automatic add_session(input int unsigned force_len);
    int unsigned kind;
    int unsigned len;
    int unsigned n;
    kind = (force_len != 0) ? 99 : $urandom_range(0, 99);
    push_word(CMD_START, 8'($urandom));
    if ($urandom_range(0, 19) == 0) push_word(CMD_TICK, 8'($urandom));
    if ($urandom_range(0, 9) == 0) push_word(CMD_BYTE, CHAR_DEL);
    if (kind < 6) begin
      // abort on a stray character inside the length
      if ($urandom_range(0, 1) != 0) push_word(CMD_BYTE, CHAR_ZERO + 8'($urandom_range(0, 9)));
      push_word(CMD_BYTE, stray_char());
    end else if (kind < 10) begin
      // overflow the length until the accumulator saturates
      repeat ($urandom_range(7, 10)) push_word(CMD_BYTE, CHAR_NINE - 8'($urandom_range(0, 2)));
      push_word(CMD_BYTE, CHAR_CR);
    end else if (kind < 14) begin
      case ($urandom_range(0, 2))
        0:       len = 0;
        1:       len = DEPTH + 1;
        default: len = $urandom_range(DEPTH + 2, 999999);
      endcase
      push_decimal(len, $urandom_range(0, 1));
      push_word(CMD_BYTE, CHAR_CR);
    end else begin
      if (force_len != 0) begin
        len = force_len;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 2)      len = $urandom_range(200, DEPTH);
        else if (n < 8) len = $urandom_range(21, 64);
        else            len = $urandom_range(1, 20);
      end
      push_decimal(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
      if ($urandom_range(0, 6) == 0) begin
        push_word(CMD_BYTE, CHAR_ZERO + 8'($urandom_range(0, 9)));
        push_word(CMD_BYTE, CHAR_DEL);
      end
      push_word(CMD_BYTE, CHAR_CR);
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          if (tmo_setting < 16) n = $urandom_range(1, int'(tmo_setting) + 1);
          else                  n = $urandom_range(1, 3);
          repeat (n) push_word(CMD_TICK, 8'($urandom));
        end
        // restart in the middle of the payload now and then
        if ($urandom_range(0, 199) == 0) begin
          push_word(CMD_START, 8'($urandom));
          return;
        end
        push_word(CMD_BYTE, 8'($urandom));
      end
    end
    // loose words between loads
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) push_word(2'($urandom_range(1, 3)), 8'($urandom));
    end
  endtask

  task automatic add_random(input int unsigned count);
    int unsigned goal;
    goal = cmd_words.size() + count;
    while (cmd_words.size() < goal) add_session(0);
  endtask

  task automatic wait_drained();
    while (cmd_words.size() != 0 || in_if.valid || loader_results_due.size() != 0)
      @(posedge clk);
  endtask

  // Write the timeout register once the loader has gone quiet
  task automatic write_timeout(input logic [TICK_W-1:0] val);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    tmo_setting = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Input side: hold a word until taken, then offer the next one or idle a burst
  always @(negedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (sender_gap > 0) begin
        sender_gap = sender_gap - 1;
        in_if.valid <= 1'b0;
      end else if (cmd_words.size() != 0) begin
        if (!calm_tail && $urandom_range(0, 7) == 0) begin
          sender_gap = $urandom_range(0, 7);
          in_if.valid <= 1'b0;
        end else begin
          w = cmd_words.pop_front();
          in_if.valid   <= 1'b1;
          in_if.cmd     <= w.cmd;
          in_if.rx_byte <= w.data;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off so the loader backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      out_if.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 150) begin
      long_hold_done = 1'b1;
      sink_hold = 120;
      out_if.ready <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(0, 7);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Predict on each accepted command word, check each accepted result word
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      in_taken     <= 1'b0;
      stall_cycles = 0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready)
        loader_results_due.push_back(step_loader(in_if.cmd, in_if.rx_byte));
      if (out_if.valid && out_if.ready) begin
        results_seen = results_seen + 1;
        if (loader_results_due.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("%0t: result word with none expected", $time);
        end else begin
          want = loader_results_due.pop_front();
          if (out_if.echo_valid !== want.echo_valid || out_if.echo_byte !== want.echo_byte ||
              out_if.event_res !== want.event_res || out_if.store_index !== want.store_index ||
              out_if.loaded_length !== want.loaded_length ||
              out_if.back_to_ready !== want.back_to_ready) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("%0t: result %0d expected echo %0b/%02h ev %0d idx %0d len %0d rdy %0b,",
                       $time, results_seen, want.echo_valid, want.echo_byte, want.event_res,
                       want.store_index, want.loaded_length, want.back_to_ready,
                       " got echo %0b/%02h ev %0d idx %0d len %0d rdy %0b",
                       out_if.echo_valid, out_if.echo_byte, out_if.event_res,
                       out_if.store_index, out_if.loaded_length, out_if.back_to_ready);
          end
        end
      end
      // watchdog: count cycles in which no word moves
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_wr_en)
        stall_cycles = 0;
      else
        stall_cycles = stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.cmd      = CMD_START;
    in_if.rx_byte  = '0;
    out_if.ready   = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    sender_gap     = 0;
    sink_hold      = 0;
    long_hold_done = 1'b0;
    calm_tail      = 1'b0;
    results_seen   = 0;
    mismatches     = 0;
    stall_cycles   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ignored words while ready, empty erase, saturation, zero length,
    // erase then accept, tick in payload, completion of a one-byte load, bad char
    push_word(CMD_BYTE, 8'hFF);
    push_word(CMD_SPARE, 8'h00);
    push_word(CMD_TICK, 8'hA5);
    push_word(CMD_START, 8'h5A);
    push_word(CMD_BYTE, CHAR_DEL);
    repeat (7) push_word(CMD_BYTE, CHAR_NINE);
    push_word(CMD_BYTE, CHAR_CR);
    push_word(CMD_START, 8'h00);
    push_word(CMD_BYTE, CHAR_ZERO);
    push_word(CMD_BYTE, CHAR_CR);
    push_word(CMD_START, 8'hFF);
    push_word(CMD_BYTE, CHAR_ZERO + 8'd1);
    push_word(CMD_BYTE, CHAR_ZERO + 8'd7);
    push_word(CMD_BYTE, CHAR_DEL);
    push_word(CMD_BYTE, CHAR_CR);
    push_word(CMD_TICK, 8'h00);
    push_word(CMD_BYTE, 8'h00);
    push_word(CMD_START, 8'h00);
    push_word(CMD_BYTE, 8'h41);   // letter: not a digit, CR or DEL
    add_random(250);

    write_timeout(24'd1);
    add_random(200);
    write_timeout(24'd0);
    add_random(150);
    write_timeout(TICK_MAX);
    add_session(DEPTH);
    add_random(150);
    write_timeout(24'($urandom_range(2, 12)));
    add_random(300);

    // last stretch runs with no idling on either side
    calm_tail = 1'b1;
    write_timeout(24'($urandom_range(3, 8)));
    add_random(250);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && loader_results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
